// ===== hw/rtl/arming_interlock_with_attitude_settle_assert.svh =====
// Assertion macros shared by the arming interlock RTL.
`ifndef ARMING_INTERLOCK_WITH_ATTITUDE_SETTLE_ASSERT_SVH
`define ARMING_INTERLOCK_WITH_ATTITUDE_SETTLE_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define AIAS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arming interlock check failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define AIAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arming interlock check failed");

`endif

// ===== hw/rtl/aias_pkg.sv =====
package aias_pkg;

    localparam int AXES      = 3;
    localparam int ANGLE_W   = 16;
    localparam int PULSE_W   = 12;
    localparam int BAND_W    = 15;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int DIFF_W    = 19;

    localparam logic signed [DIFF_W-1:0] HALF_TURN     = 19'sd18000;
    localparam logic signed [DIFF_W-1:0] FULL_TURN     = 19'sd36000;
    localparam logic signed [DIFF_W-1:0] ONE_HALF_TURN = 19'sd54000;
    localparam logic signed [DIFF_W-1:0] TWO_TURNS     = 19'sd72000;

    localparam logic [PULSE_W-1:0] ARM_HIGH_RESET       = 12'd1750;
    localparam logic [PULSE_W-1:0] ARM_LOW_RESET        = 12'd1250;
    localparam logic [PULSE_W-1:0] THROTTLE_LIMIT_RESET = 12'd1100;
    localparam logic [BAND_W-1:0]  SETTLE_BAND_RESET    = 15'd100;
    localparam logic [TIME_W-1:0]  SETTLE_TIME_RESET    = 32'd3000000;

    typedef enum logic [1:0] {
        BLK_NONE        = 2'd0,
        BLK_NO_ATTITUDE = 2'd1,
        BLK_SETTLING    = 2'd2,
        BLK_THROTTLE    = 2'd3
    } blocker_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARM_HIGH       = 3'd0,
        REG_ARM_LOW        = 3'd1,
        REG_THROTTLE_LIMIT = 3'd2,
        REG_SETTLE_BAND    = 3'd3,
        REG_SETTLE_TIME    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic               rc_new;
        logic [PULSE_W-1:0] throttle;
        logic [PULSE_W-1:0] aux_switch;
        logic               nav_new;
        logic               attitude_ok;
        logic [ANGLE_W-1:0] roll;
        logic [ANGLE_W-1:0] pitch;
        logic [ANGLE_W-1:0] yaw;
        logic [TIME_W-1:0]  now_us;
        logic               shell_request;
        logic               shell_arm;
    } item_t;

    typedef struct packed {
        logic [PULSE_W-1:0] arm_high;
        logic [PULSE_W-1:0] arm_low;
        logic [PULSE_W-1:0] throttle_limit;
    } arm_cfg_t;

    typedef struct packed {
        logic               step;
        logic               rc_seen;
        logic [PULSE_W-1:0] throttle;
        logic [PULSE_W-1:0] aux;
        logic               attitude_valid;
        logic               settled;
        logic               shell_request;
        logic               shell_arm;
    } arm_status_t;

    // Magnitude of a minus b after folding into one half turn either way.
    function automatic logic [BAND_W-1:0] wrap_mag(input logic signed [ANGLE_W-1:0] a,
                                                   input logic signed [ANGLE_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] f;
        d = DIFF_W'(a) - DIFF_W'(b);
        priority if (d > ONE_HALF_TURN)
            f = d - TWO_TURNS;
        else if (d > HALF_TURN)
            f = d - FULL_TURN;
        else if (d < -ONE_HALF_TURN)
            f = d + TWO_TURNS;
        else if (d < -HALF_TURN)
            f = d + FULL_TURN;
        else
            f = d;
        if (f < 0)
            f = -f;
        return f[BAND_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/aias_lane.sv =====
module aias_lane (
    input  logic                                clk,
    input  logic                                step,
    input  logic                                nav_new,
    input  logic signed [aias_pkg::ANGLE_W-1:0] angle,
    input  logic [aias_pkg::BAND_W-1:0]         band,
    input  logic                                restart,
    output logic                                out_of_band
);

    logic signed [aias_pkg::ANGLE_W-1:0] held_angle_reg;
    logic signed [aias_pkg::ANGLE_W-1:0] held_angle_next;
    logic signed [aias_pkg::ANGLE_W-1:0] ref_angle_reg;

    assign held_angle_next = nav_new ? angle : held_angle_reg;
    assign out_of_band = aias_pkg::wrap_mag(held_angle_next, ref_angle_reg) > band;

    always_ff @(posedge clk)
    begin
        if (step && nav_new)
        begin
            held_angle_reg <= angle;
        end
        if (restart)
        begin
            ref_angle_reg <= held_angle_next;
        end
    end

endmodule

// ===== hw/rtl/aias_arm_ctrl.sv =====
module aias_arm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  aias_pkg::arm_status_t status,
    input  aias_pkg::arm_cfg_t    cfg,
    output logic                  armed_next,
    output aias_pkg::blocker_t    blocker
);

    logic               region_reg;
    logic               region_next;
    logic               pending_reg;
    logic               pending_next;
    logic               armed_reg;
    logic               rc_arm;
    logic               rc_disarm;
    logic               pending_now;
    logic               shell_disarm;
    logic               shell_arm_req;
    aias_pkg::blocker_t attempt;

    always_comb
    begin
        rc_arm      = 1'b0;
        rc_disarm   = 1'b0;
        region_next = region_reg;
        if (status.rc_seen)
        begin
            priority if (status.aux > cfg.arm_high)
            begin
                rc_arm      = !region_reg;
                region_next = 1'b1;
            end
            else if (status.aux < cfg.arm_low)
            begin
                rc_disarm   = region_reg;
                region_next = 1'b0;
            end
            else
            begin
                region_next = region_reg;
            end
        end

        shell_disarm  = status.shell_request && !status.shell_arm;
        shell_arm_req = status.shell_request && status.shell_arm;
        pending_now   = (rc_arm || pending_reg) && region_next;

        priority if (!status.attitude_valid)
            attempt = aias_pkg::BLK_NO_ATTITUDE;
        else if (!status.settled)
            attempt = aias_pkg::BLK_SETTLING;
        else if (status.rc_seen && status.throttle > cfg.throttle_limit)
            attempt = aias_pkg::BLK_THROTTLE;
        else
            attempt = aias_pkg::BLK_NONE;

        armed_next   = armed_reg;
        pending_next = pending_now;
        blocker      = aias_pkg::BLK_NONE;
        // A disarm from either source takes precedence over any arm request.
        priority if (rc_disarm || shell_disarm)
        begin
            armed_next   = 1'b0;
            pending_next = 1'b0;
        end
        else if (pending_now || shell_arm_req)
        begin
            if (!armed_reg)
            begin
                blocker = attempt;
            end
            if (blocker == aias_pkg::BLK_NONE)
            begin
                armed_next   = 1'b1;
                pending_next = 1'b0;
            end
        end
        else
        begin
            armed_next   = armed_reg;
            pending_next = pending_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg  <= 1'b0;
            pending_reg <= 1'b0;
            armed_reg   <= 1'b0;
        end
        else if (status.step)
        begin
            region_reg  <= region_next;
            pending_reg <= pending_next;
            armed_reg   <= armed_next;
        end
    end

endmodule

// ===== hw/rtl/arming_interlock_with_attitude_settle.sv =====
// Arming interlock with attitude settle gate. Each input transaction is one update
// tick and yields exactly one output transaction carrying the armed state and the
// reason an arm attempt was refused. A tick is registered on acceptance and evaluated
// once the output stage can take a result, where one lane per attitude axis checks the
// held angle against the settle reference in parallel; the result is then registered in
// the output registers, and a new transaction is accepted every
// cycle, limited only by the output handshake. Configuration writes take effect
// at once and are meant to be issued while no transaction is in flight.
`include "arming_interlock_with_attitude_settle_assert.svh"

module arming_interlock_with_attitude_settle (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [aias_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [aias_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  rc_new,
    input  logic [aias_pkg::PULSE_W-1:0]          throttle,
    input  logic [aias_pkg::PULSE_W-1:0]          aux_switch,
    input  logic                                  nav_new,
    input  logic                                  attitude_ok,
    input  logic signed [aias_pkg::ANGLE_W-1:0]   roll,
    input  logic signed [aias_pkg::ANGLE_W-1:0]   pitch,
    input  logic signed [aias_pkg::ANGLE_W-1:0]   yaw,
    input  logic [aias_pkg::TIME_W-1:0]           now_us,
    input  logic                                  shell_request,
    input  logic                                  shell_arm,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  armed,
    output logic [1:0]                            blocker
);

    logic [aias_pkg::PULSE_W-1:0] arm_high_reg;
    logic [aias_pkg::PULSE_W-1:0] arm_low_reg;
    logic [aias_pkg::PULSE_W-1:0] throttle_limit_reg;
    logic [aias_pkg::BAND_W-1:0]  settle_band_reg;
    logic [aias_pkg::TIME_W-1:0]  settle_time_reg;

    aias_pkg::item_t              item_reg;
    logic                         item_valid_reg;
    logic                         item_valid_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_armed_reg;
    aias_pkg::blocker_t           out_blocker_reg;

    logic                         rc_seen_reg;
    logic                         nav_seen_reg;
    logic                         held_ok_reg;
    logic                         ref_set_reg;
    logic [aias_pkg::PULSE_W-1:0] held_throttle_reg;
    logic [aias_pkg::PULSE_W-1:0] held_aux_reg;
    logic [aias_pkg::TIME_W-1:0]  settle_start_reg;

    logic                         advance;
    logic                         step;
    logic                         rc_seen_now;
    logic                         nav_seen_now;
    logic                         held_ok_now;
    logic                         att_valid;
    logic                         restart;
    logic                         lane_restart;
    logic                         settled;
    logic [aias_pkg::TIME_W-1:0]  elapsed;
    logic [aias_pkg::AXES-1:0]    oob;
    logic [aias_pkg::ANGLE_W-1:0] axis_angle [3];

    aias_pkg::arm_status_t        status;
    aias_pkg::arm_cfg_t           arm_cfg;
    logic                         armed_next;
    aias_pkg::blocker_t           blocker_now;

    assign advance  = !out_valid_reg || out_ready;
    assign step     = item_valid_reg && advance;
    assign in_ready = !item_valid_reg || advance;

    assign item_valid_next = (in_valid && in_ready) ? 1'b1 : (step ? 1'b0 : item_valid_reg);
    assign out_valid_next  = step ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    assign out_valid = out_valid_reg;
    assign armed     = out_armed_reg;
    assign blocker   = out_blocker_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_high_reg       <= aias_pkg::ARM_HIGH_RESET;
            arm_low_reg        <= aias_pkg::ARM_LOW_RESET;
            throttle_limit_reg <= aias_pkg::THROTTLE_LIMIT_RESET;
            settle_band_reg    <= aias_pkg::SETTLE_BAND_RESET;
            settle_time_reg    <= aias_pkg::SETTLE_TIME_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                aias_pkg::REG_ARM_HIGH:       arm_high_reg <= cfg_data[aias_pkg::PULSE_W-1:0];
                aias_pkg::REG_ARM_LOW:        arm_low_reg <= cfg_data[aias_pkg::PULSE_W-1:0];
                aias_pkg::REG_THROTTLE_LIMIT:
                    throttle_limit_reg <= cfg_data[aias_pkg::PULSE_W-1:0];
                aias_pkg::REG_SETTLE_BAND:    settle_band_reg <= cfg_data[aias_pkg::BAND_W-1:0];
                aias_pkg::REG_SETTLE_TIME:    settle_time_reg <= cfg_data[aias_pkg::TIME_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.rc_new        <= rc_new;
            item_reg.throttle      <= throttle;
            item_reg.aux_switch    <= aux_switch;
            item_reg.nav_new       <= nav_new;
            item_reg.attitude_ok   <= attitude_ok;
            item_reg.roll          <= roll;
            item_reg.pitch         <= pitch;
            item_reg.yaw           <= yaw;
            item_reg.now_us        <= now_us;
            item_reg.shell_request <= shell_request;
            item_reg.shell_arm     <= shell_arm;
        end
        if (step)
        begin
            out_armed_reg   <= armed_next;
            out_blocker_reg <= blocker_now;
            if (item_reg.rc_new)
            begin
                held_throttle_reg <= item_reg.throttle;
                held_aux_reg      <= item_reg.aux_switch;
            end
        end
        if (lane_restart)
        begin
            settle_start_reg <= item_reg.now_us;
        end
    end

    assign rc_seen_now  = rc_seen_reg || item_reg.rc_new;
    assign nav_seen_now = nav_seen_reg || item_reg.nav_new;
    assign held_ok_now  = item_reg.nav_new ? item_reg.attitude_ok : held_ok_reg;
    assign att_valid    = nav_seen_now && held_ok_now;

    assign axis_angle[0] = item_reg.roll;
    assign axis_angle[1] = item_reg.pitch;
    assign axis_angle[2] = item_reg.yaw;

    for (genvar i = 0; i < aias_pkg::AXES; i++)
    begin : g_lane
        aias_lane u_lane (
            .clk         (clk),
            .step        (step),
            .nav_new     (item_reg.nav_new),
            .angle       ($signed(axis_angle[i])),
            .band        (settle_band_reg),
            .restart     (lane_restart),
            .out_of_band (oob[i])
        );
    end

    assign restart      = att_valid && (!ref_set_reg || (|oob));
    assign lane_restart = step && restart;
    assign elapsed      = item_reg.now_us - settle_start_reg;
    // On a restart the reference time is this tick, so zero time has elapsed.
    assign settled      = att_valid && (restart ? (settle_time_reg == '0)
                                                : (elapsed >= settle_time_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_seen_reg  <= 1'b0;
            nav_seen_reg <= 1'b0;
            held_ok_reg  <= 1'b0;
            ref_set_reg  <= 1'b0;
        end
        else if (step)
        begin
            rc_seen_reg  <= rc_seen_now;
            nav_seen_reg <= nav_seen_now;
            held_ok_reg  <= held_ok_now;
            ref_set_reg  <= att_valid;
        end
    end

    always_comb
    begin
        status.step           = step;
        status.rc_seen        = rc_seen_now;
        status.throttle       = item_reg.rc_new ? item_reg.throttle : held_throttle_reg;
        status.aux            = item_reg.rc_new ? item_reg.aux_switch : held_aux_reg;
        status.attitude_valid = att_valid;
        status.settled        = settled;
        status.shell_request  = item_reg.shell_request;
        status.shell_arm      = item_reg.shell_arm;
        arm_cfg.arm_high       = arm_high_reg;
        arm_cfg.arm_low        = arm_low_reg;
        arm_cfg.throttle_limit = throttle_limit_reg;
    end

    aias_arm_ctrl u_arm_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .status     (status),
        .cfg        (arm_cfg),
        .armed_next (armed_next),
        .blocker    (blocker_now)
    );

    `AIAS_ASSERT_SAME(a_refused_not_armed, out_valid_reg && (out_blocker_reg != aias_pkg::BLK_NONE), !out_armed_reg)
    `AIAS_ASSERT_NEXT(a_shell_disarm_wins, step && item_reg.shell_request && !item_reg.shell_arm, !out_armed_reg)
    `AIAS_ASSERT_SAME(a_ready_when_out_free, !out_valid_reg, in_ready)
    `AIAS_ASSERT_NEXT(a_reference_starts, step && att_valid && !ref_set_reg, ref_set_reg && (settle_start_reg == $past(item_reg.now_us)))

endmodule
